>>> rtl/bgh_pkg.sv
// ----------------------------------------------------------------------------
// bgh_pkg: shared types and constants of the battery gauge
// Field widths, register codes, sequencer steps, the charge curve and the
// per-segment reciprocal table used by the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package bgh_pkg;

  // Field widths.
  localparam int MV_W       = 12;
  localparam int CODE_W     = 12;
  localparam int WEIGHT_W   = 9;
  localparam int SCALE_W    = 18;
  localparam int PCT_W      = 15;
  localparam int LVL_W      = 2;
  localparam int BMV_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Internal widths.
  localparam int FILT_W = 20;
  localparam int BAT_W  = 22;
  localparam int DIFF_W = 17;
  localparam int NUM_W  = 20;
  localparam int QUO_W  = 12;
  localparam int OP_W   = 32;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 30;

  // Charge curve.
  localparam int CURVE_POINTS = 12;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int CMV_W        = 13;
  localparam int CPCT_W       = 7;
  localparam int DV_W         = 9;

  localparam logic [CMV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd3000, 13'd3300, 13'd3550, 13'd3650, 13'd3700, 13'd3750,
    13'd3790, 13'd3850, 13'd3920, 13'd4000, 13'd4100, 13'd4200};
  localparam logic [CPCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100};

  // Millivolt span of the segment that ends at point k (entry 0 unused).
  localparam logic [DV_W-1:0] SEG_DV [CURVE_POINTS] = '{
    9'd1, 9'd300, 9'd250, 9'd100, 9'd50, 9'd50,
    9'd40, 9'd60, 9'd70, 9'd80, 9'd100, 9'd100};
  // floor(2^32 / span): the quotient estimate is low by at most one.
  localparam logic [OP_W-1:0] SEG_RCP [CURVE_POINTS] = '{
    32'd0, 32'd14316557, 32'd17179869, 32'd42949672, 32'd85899345,
    32'd85899345, 32'd107374182, 32'd71582788, 32'd61356675,
    32'd53687091, 32'd42949672, 32'd42949672};

  // Converter code to pin millivolts in Q8: code * 3300 * 256 / 4095.
  localparam logic [OP_W-1:0]   CODE_GAIN  = 32'd844800;
  localparam logic [OP_W-1:0]   CODE_ROUND = 32'd2047;
  localparam logic [OP_W-1:0]   CODE_DIV   = 32'd4095;
  // floor(2^43 / 4095), again low by at most one on the quotient.
  localparam logic [OP_W-1:0]   CODE_RCP   = 32'd2148008064;
  localparam int                CODE_SHIFT = 43;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam logic [PCT_W-1:0]    PCT_FULL   = 15'd25600;
  localparam logic [BMV_W-1:0]    BMV_MAX    = 13'd8191;

  // Register defaults.
  localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST    = 9'd56;
  localparam logic [SCALE_W-1:0]  VOLTAGE_SCALE_RST = 18'd97080;
  localparam logic [PCT_W-1:0]    LOW_ENTER_RST     = 15'd7680;
  localparam logic [PCT_W-1:0]    LOW_EXIT_RST      = 15'd8192;
  localparam logic [PCT_W-1:0]    CRIT_ENTER_RST    = 15'd3840;
  localparam logic [PCT_W-1:0]    CRIT_EXIT_RST     = 15'd4352;
  localparam logic [PCT_W-1:0]    SHUT_ENTER_RST    = 15'd1280;
  localparam logic [PCT_W-1:0]    SHUT_EXIT_RST     = 15'd1792;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMA_WEIGHT    = 3'd0,
    REG_VOLTAGE_SCALE = 3'd1,
    REG_LOW_ENTER     = 3'd2,
    REG_LOW_EXIT      = 3'd3,
    REG_CRIT_ENTER    = 3'd4,
    REG_CRIT_EXIT     = 3'd5,
    REG_SHUT_ENTER    = 3'd6,
    REG_SHUT_EXIT     = 3'd7
  } cfg_idx_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_LOW      = 2'd1,
    LVL_CRITICAL = 2'd2,
    LVL_SHUTDOWN = 2'd3
  } level_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] ema_weight;
    logic [SCALE_W-1:0]  voltage_scale;
    logic [PCT_W-1:0]    low_enter_pct;
    logic [PCT_W-1:0]    low_exit_pct;
    logic [PCT_W-1:0]    critical_enter_pct;
    logic [PCT_W-1:0]    critical_exit_pct;
    logic [PCT_W-1:0]    shutdown_enter_pct;
    logic [PCT_W-1:0]    shutdown_exit_pct;
  } cfg_t;

  // Sequencer steps.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CODE_MUL,
    ST_CODE_ADD,
    ST_RECIP_MUL,
    ST_QEST,
    ST_CORR_MUL,
    ST_CORR,
    ST_FILT_SEL,
    ST_EMA_A,
    ST_EMA_B,
    ST_EMA_C,
    ST_SCALE,
    ST_BAT,
    ST_SEG,
    ST_NUM_MUL,
    ST_NUM_ADD,
    ST_DIV_MUL,
    ST_DIV_Q,
    ST_DIV_CHK,
    ST_DIV_FIX,
    ST_LEVEL
  } state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_CODE,
    MUL_RECIP,
    MUL_CORR,
    MUL_EMA_OLD,
    MUL_EMA_NEW,
    MUL_SCALE,
    MUL_NUM,
    MUL_DIV,
    MUL_CHK
  } mul_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    ld_in;
    logic    ld_n;
    logic    ld_qest;
    logic    ld_qfix;
    logic    ld_first;
    logic    ld_acc;
    logic    ld_ema;
    logic    ld_bat;
    logic    ld_seg;
    logic    ld_num;
    logic    ld_quo;
    logic    ld_pct;
    logic    ld_out;
  } ctrl_t;

  typedef struct packed {
    logic use_code;
    logic first;
    logic in_range;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/bgh_in_if.sv
// ----------------------------------------------------------------------------
// bgh_in_if: reading channel
// One beat carries one averaged reading of the battery sense pin.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgh_in_if;
  import bgh_pkg::*;

  logic              valid;
  logic              ready;
  logic [MV_W-1:0]   pin_millivolts;
  logic [CODE_W-1:0] adc_code;

  modport source (output valid, output pin_millivolts, output adc_code, input ready);
  modport sink   (input valid, input pin_millivolts, input adc_code, output ready);
endinterface

`default_nettype wire

>>> rtl/bgh_out_if.sv
// ----------------------------------------------------------------------------
// bgh_out_if: result channel
// One beat carries level, percent and battery voltage of one reading.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgh_out_if;
  import bgh_pkg::*;

  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] charge_level;
  logic             level_changed;
  logic [PCT_W-1:0] charge_percent;
  logic [BMV_W-1:0] battery_millivolts;
  logic             inputs_locked;

  modport source (output valid, output charge_level, output level_changed,
                  output charge_percent, output battery_millivolts,
                  output inputs_locked, input ready);
  modport sink   (input valid, input charge_level, input level_changed,
                  input charge_percent, input battery_millivolts,
                  input inputs_locked, output ready);
endinterface

`default_nettype wire

>>> rtl/bgh_ctrl.sv
// ----------------------------------------------------------------------------
// bgh_ctrl: step sequencer
// Walks one reading through the steps of the shared multiplier datapath and
// raises the load strobes of each step.
// ----------------------------------------------------------------------------
`default_nettype none

module bgh_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire bgh_pkg::stat_t stat,
  output bgh_pkg::ctrl_t      ctrl,
  output logic                in_ready
);
  import bgh_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.use_code ? ST_CODE_MUL : ST_FILT_SEL;
        end
      end
      ST_CODE_MUL:  state_next = ST_CODE_ADD;
      ST_CODE_ADD:  state_next = ST_RECIP_MUL;
      ST_RECIP_MUL: state_next = ST_QEST;
      ST_QEST:      state_next = ST_CORR_MUL;
      ST_CORR_MUL:  state_next = ST_CORR;
      ST_CORR:      state_next = ST_FILT_SEL;
      ST_FILT_SEL:  state_next = stat.first ? ST_SCALE : ST_EMA_A;
      ST_EMA_A:     state_next = ST_EMA_B;
      ST_EMA_B:     state_next = ST_EMA_C;
      ST_EMA_C:     state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_BAT;
      ST_BAT:       state_next = ST_SEG;
      ST_SEG:       state_next = stat.in_range ? ST_NUM_MUL : ST_LEVEL;
      ST_NUM_MUL:   state_next = ST_NUM_ADD;
      ST_NUM_ADD:   state_next = ST_DIV_MUL;
      ST_DIV_MUL:   state_next = ST_DIV_Q;
      ST_DIV_Q:     state_next = ST_DIV_CHK;
      ST_DIV_CHK:   state_next = ST_DIV_FIX;
      ST_DIV_FIX:   state_next = ST_LEVEL;
      ST_LEVEL: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Step outputs.
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctrl.ld_in = in_valid;
      end
      ST_CODE_MUL:  ctrl.mul_op = MUL_CODE;
      ST_CODE_ADD:  ctrl.ld_n = 1'b1;
      ST_RECIP_MUL: ctrl.mul_op = MUL_RECIP;
      ST_QEST:      ctrl.ld_qest = 1'b1;
      ST_CORR_MUL:  ctrl.mul_op = MUL_CORR;
      ST_CORR:      ctrl.ld_qfix = 1'b1;
      ST_FILT_SEL: begin
        ctrl.ld_first = stat.first;
      end
      ST_EMA_A:     ctrl.mul_op = MUL_EMA_OLD;
      ST_EMA_B: begin
        ctrl.mul_op = MUL_EMA_NEW;
        ctrl.ld_acc = 1'b1;
      end
      ST_EMA_C:     ctrl.ld_ema = 1'b1;
      ST_SCALE:     ctrl.mul_op = MUL_SCALE;
      ST_BAT:       ctrl.ld_bat = 1'b1;
      ST_SEG:       ctrl.ld_seg = 1'b1;
      ST_NUM_MUL:   ctrl.mul_op = MUL_NUM;
      ST_NUM_ADD:   ctrl.ld_num = 1'b1;
      ST_DIV_MUL:   ctrl.mul_op = MUL_DIV;
      ST_DIV_Q:     ctrl.ld_quo = 1'b1;
      ST_DIV_CHK:   ctrl.mul_op = MUL_CHK;
      ST_DIV_FIX:   ctrl.ld_pct = 1'b1;
      ST_LEVEL:     ctrl.ld_out = !stat.out_busy;
      default:      ctrl = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bgh_dp.sv
// ----------------------------------------------------------------------------
// bgh_dp: gauge datapath
// Shared 32x32 multiplier with its operand select, the working registers of
// one reading, the level hysteresis and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bgh_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bgh_pkg::cfg_t                cfg,
  input  wire bgh_pkg::ctrl_t               ctrl,
  output bgh_pkg::stat_t                    stat,
  input  wire logic [bgh_pkg::MV_W-1:0]     pin_millivolts,
  input  wire logic [bgh_pkg::CODE_W-1:0]   adc_code,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [bgh_pkg::LVL_W-1:0]         charge_level,
  output logic                              level_changed,
  output logic [bgh_pkg::PCT_W-1:0]         charge_percent,
  output logic [bgh_pkg::BMV_W-1:0]         battery_millivolts,
  output logic                              inputs_locked
);
  import bgh_pkg::*;

  // Working registers.
  logic [CODE_W-1:0] code;
  logic [OP_W-1:0]   n;
  logic [FILT_W-1:0] qest;
  logic [FILT_W-1:0] sample;
  logic [FILT_W-1:0] filt;
  logic              reading_valid;
  logic [ACC_W-1:0]  acc;
  logic [BAT_W-1:0]  bat;
  logic [SEG_W-1:0]  seg;
  logic [DIFF_W-1:0] diff;
  logic [NUM_W-1:0]  num;
  logic [QUO_W-1:0]  quo;
  logic [PCT_W-1:0]  pct;
  level_t            level_now;
  logic [PROD_W-1:0] prod;

  logic [OP_W-1:0]     op_a;
  logic [OP_W-1:0]     op_b;
  logic [WEIGHT_W-1:0] weight;
  logic [WEIGHT_W-1:0] weight_inv;

  // Weights above one act as one.
  assign weight     = (cfg.ema_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.ema_weight;
  assign weight_inv = WEIGHT_ONE - weight;

  // Operand select of the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.mul_op)
      MUL_CODE: begin
        op_a = OP_W'(code);
        op_b = CODE_GAIN;
      end
      MUL_RECIP: begin
        op_a = n;
        op_b = CODE_RCP;
      end
      MUL_CORR: begin
        op_a = OP_W'(qest);
        op_b = CODE_DIV;
      end
      MUL_EMA_OLD: begin
        op_a = OP_W'(filt);
        op_b = OP_W'(weight_inv);
      end
      MUL_EMA_NEW: begin
        op_a = OP_W'(sample);
        op_b = OP_W'(weight);
      end
      MUL_SCALE: begin
        op_a = OP_W'(filt);
        op_b = OP_W'(cfg.voltage_scale);
      end
      MUL_NUM: begin
        op_a = OP_W'(diff);
        op_b = OP_W'(CURVE_PCT[seg] - CURVE_PCT[seg - SEG_W'(1)]);
      end
      MUL_DIV: begin
        op_a = OP_W'(num);
        op_b = SEG_RCP[seg];
      end
      MUL_CHK: begin
        op_a = OP_W'(quo);
        op_b = OP_W'(SEG_DV[seg]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Product register.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Fallback remainder check of the code-to-millivolt division.
  logic [OP_W-1:0] code_rem;
  assign code_rem = n - prod[OP_W-1:0];

  // Moving average sum and battery voltage rounding.
  logic [ACC_W-1:0] ema_sum;
  logic [39:0]      bat_sum;
  assign ema_sum = acc + prod[ACC_W-1:0];
  assign bat_sum = prod[39:0] + 40'd32768;

  // Curve segment search over the constant points.
  logic [BAT_W-1:0] curve_first;
  logic [BAT_W-1:0] curve_last;
  logic [SEG_W-1:0] seg_hit;
  assign curve_first = BAT_W'(CURVE_MV[0]) << 8;
  assign curve_last  = BAT_W'(CURVE_MV[CURVE_POINTS-1]) << 8;

  always_comb begin
    seg_hit = SEG_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (bat <= (BAT_W'(CURVE_MV[i]) << 8)) begin
        seg_hit = SEG_W'(i);
      end
    end
  end

  logic [BAT_W-1:0] seg_lo;
  assign seg_lo = BAT_W'(CURVE_MV[seg_hit - SEG_W'(1)]) << 8;

  // Quotient fix-up of the segment division and the percent sum.
  logic [NUM_W-1:0] div_rem;
  logic [QUO_W-1:0] quo_fix;
  logic [PCT_W-1:0] pct_sum;
  assign div_rem = num - prod[NUM_W-1:0];
  assign quo_fix = (div_rem >= NUM_W'(SEG_DV[seg])) ? quo + QUO_W'(1) : quo;
  assign pct_sum = (PCT_W'(CURVE_PCT[seg - SEG_W'(1)]) << 8) + PCT_W'(quo_fix);

  // Level hysteresis.
  level_t level_new;
  always_comb begin
    level_new = level_now;
    case (level_now)
      LVL_NORMAL: begin
        if (pct < cfg.shutdown_enter_pct)      level_new = LVL_SHUTDOWN;
        else if (pct < cfg.critical_enter_pct) level_new = LVL_CRITICAL;
        else if (pct < cfg.low_enter_pct)      level_new = LVL_LOW;
        else                                   level_new = LVL_NORMAL;
      end
      LVL_LOW: begin
        if (pct < cfg.shutdown_enter_pct)      level_new = LVL_SHUTDOWN;
        else if (pct < cfg.critical_enter_pct) level_new = LVL_CRITICAL;
        else if (pct >= cfg.low_exit_pct)      level_new = LVL_NORMAL;
        else                                   level_new = LVL_LOW;
      end
      LVL_CRITICAL: begin
        if (pct < cfg.shutdown_enter_pct)      level_new = LVL_SHUTDOWN;
        else if (pct >= cfg.low_exit_pct)      level_new = LVL_NORMAL;
        else if (pct >= cfg.critical_exit_pct) level_new = LVL_LOW;
        else                                   level_new = LVL_CRITICAL;
      end
      default: begin
        if (pct >= cfg.low_exit_pct)           level_new = LVL_NORMAL;
        else if (pct >= cfg.critical_exit_pct) level_new = LVL_LOW;
        else if (pct >= cfg.shutdown_exit_pct) level_new = LVL_CRITICAL;
        else                                   level_new = LVL_SHUTDOWN;
      end
    endcase
  end

  // Whole millivolts, rounded and saturated.
  logic [BAT_W:0]   bmv_sum;
  logic [BAT_W-8:0] bmv_full;
  logic [BMV_W-1:0] bmv;
  assign bmv_sum  = {1'b0, bat} + (BAT_W+1)'(128);
  assign bmv_full = bmv_sum[BAT_W:8];
  assign bmv      = (bmv_full > (BAT_W-7)'(BMV_MAX)) ? BMV_MAX : bmv_full[BMV_W-1:0];

  // Status to the sequencer.
  assign stat.use_code = (pin_millivolts == '0) && (adc_code != '0);
  assign stat.first    = !reading_valid;
  assign stat.in_range = (bat > curve_first) && (bat < curve_last);
  assign stat.out_busy = out_valid && !out_ready;

  // Payload registers of one reading.
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      code   <= adc_code;
      sample <= FILT_W'(pin_millivolts) << 8;
    end
    if (ctrl.ld_n) begin
      n <= prod[OP_W-1:0] + CODE_ROUND;
    end
    if (ctrl.ld_qest) begin
      qest <= prod[CODE_SHIFT+FILT_W-1:CODE_SHIFT];
    end
    if (ctrl.ld_qfix) begin
      sample <= (code_rem >= CODE_DIV) ? qest + FILT_W'(1) : qest;
    end
    if (ctrl.ld_acc) begin
      acc <= prod[ACC_W-1:0] + ACC_W'(128);
    end
    if (ctrl.ld_bat) begin
      bat <= bat_sum[16+BAT_W-1:16];
    end
    if (ctrl.ld_seg) begin
      seg  <= seg_hit;
      diff <= DIFF_W'(bat - seg_lo);
      if (bat <= curve_first) begin
        pct <= PCT_W'(CURVE_PCT[0]) << 8;
      end else if (bat >= curve_last) begin
        pct <= PCT_W'(CURVE_PCT[CURVE_POINTS-1]) << 8;
      end
    end
    if (ctrl.ld_num) begin
      num <= prod[NUM_W-1:0] + NUM_W'(SEG_DV[seg] >> 1);
    end
    if (ctrl.ld_quo) begin
      quo <= prod[32+QUO_W-1:32];
    end
    if (ctrl.ld_pct) begin
      pct <= (pct_sum > PCT_FULL) ? PCT_FULL : pct_sum;
    end
  end

  // Filter state; the first reading loads it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      filt          <= '0;
      reading_valid <= 1'b0;
    end else if (ctrl.ld_first) begin
      filt          <= sample;
      reading_valid <= 1'b1;
    end else if (ctrl.ld_ema) begin
      filt <= ema_sum[FILT_W+7:8];
    end
  end

  // Level state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_now <= LVL_NORMAL;
      out_valid <= 1'b0;
    end else if (ctrl.ld_out) begin
      level_now <= level_new;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      charge_level       <= level_new;
      level_changed      <= (level_new != level_now);
      charge_percent     <= pct;
      battery_millivolts <= bmv;
      inputs_locked      <= reading_valid && (level_new == LVL_SHUTDOWN);
    end
  end

endmodule

`default_nettype wire

>>> rtl/battery_gauge_hysteresis.sv
// ----------------------------------------------------------------------------
// battery_gauge_hysteresis: battery charge gauge with alarm hysteresis
// An accepted beat passes the filter, scale, segment and level steps, plus the
// moving average, the division inside the curve and the converter-code fallback.
// A reading holds the one shared 32x32 multiplier; no new beat is taken until its
// result enters the output register, which waits while the previous result waits.
// Reset loads the register defaults, empties the filter and sets level normal.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_gauge_hysteresis (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bgh_in_if.sink                               sample_in,
  bgh_out_if.source                            result_out,
  input  wire logic                            cfg_we,
  input  wire logic [bgh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bgh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bgh_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ema_weight         <= EMA_WEIGHT_RST;
      cfg.voltage_scale      <= VOLTAGE_SCALE_RST;
      cfg.low_enter_pct      <= LOW_ENTER_RST;
      cfg.low_exit_pct       <= LOW_EXIT_RST;
      cfg.critical_enter_pct <= CRIT_ENTER_RST;
      cfg.critical_exit_pct  <= CRIT_EXIT_RST;
      cfg.shutdown_enter_pct <= SHUT_ENTER_RST;
      cfg.shutdown_exit_pct  <= SHUT_EXIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_EMA_WEIGHT:    cfg.ema_weight         <= cfg_data[WEIGHT_W-1:0];
        REG_VOLTAGE_SCALE: cfg.voltage_scale      <= cfg_data[SCALE_W-1:0];
        REG_LOW_ENTER:     cfg.low_enter_pct      <= cfg_data[PCT_W-1:0];
        REG_LOW_EXIT:      cfg.low_exit_pct       <= cfg_data[PCT_W-1:0];
        REG_CRIT_ENTER:    cfg.critical_enter_pct <= cfg_data[PCT_W-1:0];
        REG_CRIT_EXIT:     cfg.critical_exit_pct  <= cfg_data[PCT_W-1:0];
        REG_SHUT_ENTER:    cfg.shutdown_enter_pct <= cfg_data[PCT_W-1:0];
        REG_SHUT_EXIT:     cfg.shutdown_exit_pct  <= cfg_data[PCT_W-1:0];
        default:           cfg.ema_weight         <= cfg.ema_weight;
      endcase
    end
  end

  // Step sequencer.
  bgh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (sample_in.ready)
  );

  // Datapath with the shared multiplier.
  bgh_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .ctrl               (ctrl),
    .stat               (stat),
    .pin_millivolts     (sample_in.pin_millivolts),
    .adc_code           (sample_in.adc_code),
    .out_valid          (result_out.valid),
    .out_ready          (result_out.ready),
    .charge_level       (result_out.charge_level),
    .level_changed      (result_out.level_changed),
    .charge_percent     (result_out.charge_percent),
    .battery_millivolts (result_out.battery_millivolts),
    .inputs_locked      (result_out.inputs_locked)
  );

endmodule

`default_nettype wire
